// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest engine.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

  localparam int WordW  = 32;
  localparam int CountW = 61;
  localparam int LenW   = 64;
  localparam int Rounds = 64;
  localparam int RndW   = $clog2(Rounds);
  localparam int FillW  = 6;
  localparam int BufDepth = 16;
  localparam int BufAddrW = $clog2(BufDepth);

  localparam logic [FillW-1:0] FillLast   = 6'd63;
  localparam logic [FillW-1:0] FillLenPos = 6'd56;
  localparam logic [7:0]       PadMark    = 8'h80;
  localparam logic [RndW-1:0]  RndLast    = 6'd63;

  localparam logic [WordW-1:0] InitA = 32'h67452301;
  localparam logic [WordW-1:0] InitB = 32'hefcdab89;
  localparam logic [WordW-1:0] InitC = 32'h98badcfe;
  localparam logic [WordW-1:0] InitD = 32'h10325476;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  // byte write into the block buffer
  typedef struct packed {
    logic                we;
    logic [BufAddrW-1:0] word;
    logic [1:0]          lane;
    logic [7:0]          data;
  } md5_buf_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPRESS,
    S_UPDATE,
    S_PAD,
    S_DONE
  } md5_state_t;

  function automatic logic [WordW-1:0] sine_k(input logic [RndW-1:0] r);
    logic [WordW-1:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [RndW-1:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word used by each round
  function automatic logic [BufAddrW-1:0] msg_index(input logic [RndW-1:0] r);
    logic [BufAddrW-1:0] r4;
    logic [BufAddrW-1:0] g;
    r4 = r[BufAddrW-1:0];
    case (r[5:4])
      2'd0:    g = r4;
      2'd1:    g = 4'({r4, 2'b00} + r4 + 4'd1);
      2'd2:    g = 4'({r4, 1'b0} + r4 + 4'd5);
      default: g = 4'({r4, 3'b000} - {1'b0, r4});
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest
// Streaming MD5 engine: byte intake, padding, 64-round compression, digest.
// ----------------------------------------------------------------------------
// Channel  | Signals                    | Payload
// item     | item_valid / item_ready    | md5_in_t: data_byte, has_byte, end_of_message
// digest   | digest_valid / digest_ready| md5_out_t: digest_word, word_index, last_word
//
// Bytes are taken while idle. Every 64th byte starts the compression: 64
// rounds on the shared round unit, then the chaining add. End of message
// pads one byte per cycle, pausing to compress a full block (up to 72 bytes,
// one or two blocks), then hands the digest to the output register, four transfers.
// item_ready is low while compressing, padding, or while a finished digest
// cannot yet be loaded because the previous one is still draining.
// Synchronous reset rst restores the initial chaining values.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_message_digest (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_ready,
  input  md5_pkg::md5_in_t   item,
  output logic               digest_valid,
  input  wire                digest_ready,
  output md5_pkg::md5_out_t  digest
);

  localparam int W = md5_pkg::WordW;

  md5_pkg::md5_state_t state, state_next;

  logic [md5_pkg::RndW-1:0]   rnd;
  logic [md5_pkg::RndW-1:0]   rd_rnd;
  logic [md5_pkg::FillW-1:0]  fill;
  logic [md5_pkg::CountW-1:0] count;
  logic [md5_pkg::CountW-1:0] count_next;
  logic [md5_pkg::LenW-1:0]   len_bits;
  logic pad_active, mark_sent, len_started, pad_done;

  logic [W-1:0] ch_a, ch_b, ch_c, ch_d;
  logic [W-1:0] wa, wb, wc, wd;
  logic [W-1:0] b_new;
  logic [W-1:0] msg_word;
  logic [W-1:0] dig [4];
  logic         out_busy;
  logic [1:0]   out_idx;

  logic                  accept;
  logic                  push_en;
  logic [7:0]            push_byte;
  logic                  len_phase;
  md5_pkg::md5_buf_wr_t  buf_wr;

  assign accept     = item_valid && item_ready;
  assign count_next = item.has_byte ? count + 1'b1 : count;
  assign len_phase  = mark_sent && (len_started || fill == md5_pkg::FillLenPos);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      md5_pkg::S_IDLE: begin
        if (accept) begin
          if (item.has_byte && fill == md5_pkg::FillLast) begin
            state_next = md5_pkg::S_COMPRESS;
          end else if (item.end_of_message) begin
            state_next = md5_pkg::S_PAD;
          end
        end
      end
      md5_pkg::S_COMPRESS: begin
        if (rnd == md5_pkg::RndLast) begin
          state_next = md5_pkg::S_UPDATE;
        end
      end
      md5_pkg::S_UPDATE: begin
        if (pad_done) begin
          state_next = md5_pkg::S_DONE;
        end else if (pad_active) begin
          state_next = md5_pkg::S_PAD;
        end else begin
          state_next = md5_pkg::S_IDLE;
        end
      end
      md5_pkg::S_PAD: begin
        if (fill == md5_pkg::FillLast) begin
          state_next = md5_pkg::S_COMPRESS;
        end
      end
      md5_pkg::S_DONE: begin
        if (!out_busy) begin
          state_next = md5_pkg::S_IDLE;
        end
      end
      default: state_next = md5_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready = 1'b0;
    push_en    = 1'b0;
    push_byte  = item.data_byte;
    unique case (state)
      md5_pkg::S_IDLE: begin
        item_ready = 1'b1;
        push_en    = item_valid && item.has_byte;
      end
      md5_pkg::S_PAD: begin
        push_en = 1'b1;
        if (!mark_sent) begin
          push_byte = md5_pkg::PadMark;
        end else if (len_phase) begin
          push_byte = len_bits[{fill[2:0], 3'b000} +: 8];
        end else begin
          push_byte = 8'h00;
        end
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  assign buf_wr.we   = push_en;
  assign buf_wr.word = fill[md5_pkg::FillW-1:2];
  assign buf_wr.lane = fill[1:0];
  assign buf_wr.data = push_byte;

  // fetch the next round's message word, since the buffer read is registered
  assign rd_rnd = (state == md5_pkg::S_COMPRESS) ? rnd + 1'b1 : '0;

  md5_blk_buf #(
    .Width (md5_pkg::WordW),
    .Depth (md5_pkg::BufDepth)
  ) u_buf (
    .clk     (clk),
    .we      (buf_wr.we),
    .wr_addr (buf_wr.word),
    .wr_lane (buf_wr.lane),
    .wr_data (buf_wr.data),
    .rd_addr (md5_pkg::msg_index(rd_rnd)),
    .rd_data (msg_word)
  );

  md5_round u_round (
    .rnd   (rnd),
    .a     (wa),
    .b     (wb),
    .c     (wc),
    .d     (wd),
    .m     (msg_word),
    .b_new (b_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= md5_pkg::S_IDLE;
      rnd         <= '0;
      fill        <= '0;
      count       <= '0;
      pad_active  <= 1'b0;
      mark_sent   <= 1'b0;
      len_started <= 1'b0;
      pad_done    <= 1'b0;
      ch_a        <= md5_pkg::InitA;
      ch_b        <= md5_pkg::InitB;
      ch_c        <= md5_pkg::InitC;
      ch_d        <= md5_pkg::InitD;
      out_busy    <= 1'b0;
      out_idx     <= '0;
    end else begin
      state <= state_next;

      if (push_en) begin
        fill <= fill + 1'b1;
      end

      // latch the working copy as the last byte of a block lands
      if (push_en && fill == md5_pkg::FillLast) begin
        wa <= ch_a;
        wb <= ch_b;
        wc <= ch_c;
        wd <= ch_d;
      end

      if (accept) begin
        count <= count_next;
        if (item.end_of_message) begin
          pad_active <= 1'b1;
          len_bits   <= {count_next, 3'b000};
        end
      end

      if (state == md5_pkg::S_PAD) begin
        if (!mark_sent) begin
          mark_sent <= 1'b1;
        end else if (fill == md5_pkg::FillLenPos) begin
          len_started <= 1'b1;
        end
        if (len_phase && fill == md5_pkg::FillLast) begin
          pad_done <= 1'b1;
        end
      end

      if (state == md5_pkg::S_COMPRESS) begin
        wa  <= wd;
        wb  <= b_new;
        wc  <= wb;
        wd  <= wc;
        rnd <= rnd + 1'b1;
      end

      if (state == md5_pkg::S_UPDATE) begin
        ch_a <= ch_a + wa;
        ch_b <= ch_b + wb;
        ch_c <= ch_c + wc;
        ch_d <= ch_d + wd;
      end

      // advance through the four digest words
      if (out_busy && digest_ready) begin
        out_idx <= out_idx + 1'b1;
        if (out_idx == 2'd3) begin
          out_busy <= 1'b0;
        end
      end

      // hand off the digest and start the next message
      if (state == md5_pkg::S_DONE && !out_busy) begin
        dig[0]      <= ch_a;
        dig[1]      <= ch_b;
        dig[2]      <= ch_c;
        dig[3]      <= ch_d;
        out_busy    <= 1'b1;
        out_idx     <= '0;
        ch_a        <= md5_pkg::InitA;
        ch_b        <= md5_pkg::InitB;
        ch_c        <= md5_pkg::InitC;
        ch_d        <= md5_pkg::InitD;
        count       <= '0;
        pad_active  <= 1'b0;
        mark_sent   <= 1'b0;
        len_started <= 1'b0;
        pad_done    <= 1'b0;
      end
    end
  end

  assign digest_valid       = out_busy;
  assign digest.digest_word = dig[out_idx];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == 2'd3);

  a_compress_fill: assert property (@(posedge clk) disable iff (rst)
    state == md5_pkg::S_COMPRESS |-> fill == '0)
    else $error("block buffer not empty during compression");

  a_rounds_done: assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::S_COMPRESS && rnd == md5_pkg::RndLast) |=>
      (state == md5_pkg::S_UPDATE && rnd == '0))
    else $error("compression did not end after the last round");

  a_end_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && item.end_of_message) |=> state != md5_pkg::S_IDLE)
    else $error("end of message did not start padding");

  a_digest_fresh: assert property (@(posedge clk) disable iff (rst)
    $rose(out_busy) |-> (count == '0 && fill == '0 && out_idx == '0))
    else $error("digest loaded without reinitializing");

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !out_busy |-> out_idx == '0)
    else $error("digest word index not cleared after last transfer");

endmodule

`default_nettype wire

// ===== rtl/md5_blk_buf.sv =====
// ----------------------------------------------------------------------------
// md5_blk_buf
// Small RAM with byte-lane writes and a registered word read.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_blk_buf #(
  parameter int Width = md5_pkg::WordW,
  parameter int Depth = md5_pkg::BufDepth
) (
  input  wire                        clk,
  input  wire                        we,
  input  wire [$clog2(Depth)-1:0]    wr_addr,
  input  wire [$clog2(Width/8)-1:0]  wr_lane,
  input  wire [7:0]                  wr_data,
  input  wire [$clog2(Depth)-1:0]    rd_addr,
  output logic [Width-1:0]           rd_data
);

  logic [Width-1:0] words [Depth];

  // bytes land in order, so each word is complete before a block is read
  always_ff @(posedge clk) begin
    if (we) begin
      words[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_data;
    end
    rd_data <= words[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/md5_round.sv =====
// ----------------------------------------------------------------------------
// md5_round
// One MD5 round step: round function, add chain and left rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_round (
  input  wire [md5_pkg::RndW-1:0]  rnd,
  input  wire [md5_pkg::WordW-1:0] a,
  input  wire [md5_pkg::WordW-1:0] b,
  input  wire [md5_pkg::WordW-1:0] c,
  input  wire [md5_pkg::WordW-1:0] d,
  input  wire [md5_pkg::WordW-1:0] m,
  output logic [md5_pkg::WordW-1:0] b_new
);

  logic [md5_pkg::WordW-1:0]   f;
  logic [md5_pkg::WordW-1:0]   sum;
  logic [2*md5_pkg::WordW-1:0] dbl;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  assign sum   = a + f + md5_pkg::sine_k(rnd) + m;
  assign dbl   = {sum, sum} << md5_pkg::rot_amt(rnd);
  assign b_new = b + dbl[2*md5_pkg::WordW-1:md5_pkg::WordW];

endmodule

`default_nettype wire
